[hdl/pidt_pkg.sv]
package pidt_pkg;

    // gain layout shared by the datapath and the tuner
    localparam int NUM_GAINS = 3;
    localparam logic [1:0] G_KP = 2'd0;
    localparam logic [1:0] G_KI = 2'd1;
    localparam logic [1:0] G_KD = 2'd2;

    // opcodes of the sample channel
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TUNE   = 1'b1;

    // configuration register map, word index on paddr[4:2]
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_KP_START   = 3'd0;
    localparam logic [2:0] REG_KI_START   = 3'd1;
    localparam logic [2:0] REG_KD_START   = 3'd2;
    localparam logic [2:0] REG_TOLERANCE  = 3'd3;
    localparam logic [2:0] REG_START_STEP = 3'd4;

    // register reset values
    localparam logic [31:0] TOL_RESET  = 32'd328;
    localparam logic [31:0] STEP_RESET = 32'd65536;

    // reciprocal of ten for 32 bit operands: q = (s * RECIP_10) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef logic signed [31:0] t_gain;
    typedef t_gain t_gains [NUM_GAINS];

    // pid error terms, Q8.8 based
    typedef struct packed {
        logic signed [15:0] prop;
        logic signed [16:0] deriv;
        logic signed [31:0] integ;
    } t_terms;

endpackage

[hdl/pidt_in_if.sv]
interface pidt_in_if;
    import pidt_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] error_sample;
    logic [31:0]        episode_sse;

    modport source (output valid, output opcode, output error_sample, output episode_sse,
                    input ready);
    modport sink   (input valid, input opcode, input error_sample, input episode_sse,
                    output ready);
endinterface

[hdl/pidt_out_if.sv]
interface pidt_out_if;
    import pidt_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               tuning_done;
    logic signed [31:0] best_kp;
    logic signed [31:0] best_ki;
    logic signed [31:0] best_kd;
    logic [15:0]        tune_steps;

    modport source (output valid, output drive, output tuning_done, output best_kp,
                    output best_ki, output best_kd, output tune_steps, input ready);
    modport sink   (input valid, input drive, input tuning_done, input best_kp,
                    input best_ki, input best_kd, input tune_steps, output ready);
endinterface

[hdl/pidt_drive.sv]
module pidt_drive
    import pidt_pkg::*;
(
    input  logic signed [15:0] i_err,
    input  t_terms             i_terms,
    input  t_gains             i_gains,
    output t_terms             o_terms,
    output logic signed [31:0] o_drive
);

    logic signed [16:0] deriv;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ;
    logic signed [63:0] prod_p;
    logic signed [63:0] prod_d;
    logic signed [63:0] prod_i;
    logic signed [65:0] pid_sum;
    logic signed [65:0] neg_shift;

    // derivative and saturating integral
    assign deriv     = 17'(i_err) - 17'(i_terms.prop);
    assign integ_sum = 33'(i_terms.integ) + 33'(i_err);

    always_comb begin
        if (integ_sum > 33'sd2147483647) begin
            integ = 32'sh7FFF_FFFF;
        end else if (integ_sum < -33'sd2147483648) begin
            integ = 32'sh8000_0000;
        end else begin
            integ = integ_sum[31:0];
        end
    end

    // three gain products, exact sum
    assign prod_p = 64'(i_gains[G_KP]) * 64'(i_err);
    assign prod_d = 64'(i_gains[G_KD]) * 64'(deriv);
    assign prod_i = 64'(i_gains[G_KI]) * 64'(integ);

    assign pid_sum   = 66'(prod_p) + 66'(prod_d) + 66'(prod_i);
    assign neg_shift = (-pid_sum) >>> 8;

    // saturate the negated sum to q16.16
    always_comb begin
        if (neg_shift > 66'sd2147483647) begin
            o_drive = 32'sh7FFF_FFFF;
        end else if (neg_shift < -66'sd2147483648) begin
            o_drive = 32'sh8000_0000;
        end else begin
            o_drive = neg_shift[31:0];
        end
    end

    assign o_terms.prop  = i_err;
    assign o_terms.deriv = deriv;
    assign o_terms.integ = integ;

endmodule

[hdl/pid_controller_with_twiddle_tuning_core.sv]
// channel   dir  payload                                        transaction when
// i_smp     in   opcode, error_sample, episode_sse              valid && ready
// o_res     out  drive, tuning_done, best_kp/ki/kd, tune_steps  valid && ready
// apb       in   psel, penable, pwrite, paddr, pwdata / prdata  psel && penable && pwrite
//
// one item per cycle sustained while o_res is not stalled; an item taken into the input
// register moves on to the result register when that register is free (pid products and
// twiddle update between the two registers), and the result register then offers it.
// reset is synchronous, active low, and clears all control and tuning state
// a stalled result holds in the output register while one more item waits in the
// input register; pready is tied high
module pid_controller_with_twiddle_tuning_core
    import pidt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    pidt_in_if.sink               i_smp,
    pidt_out_if.source            o_res
);

    // pipeline registers
    logic               r_in_vld;
    logic               r_in_op;
    logic signed [15:0] r_in_err;
    logic [31:0]        r_in_sse;
    logic               r_out_vld;
    logic signed [31:0] r_out_drive;
    logic               r_out_done;
    t_gains             r_out_best;
    logic [15:0]        r_out_steps;

    // configuration
    logic [31:0] r_cfg_kp, n_cfg_kp;
    logic [31:0] r_cfg_ki, n_cfg_ki;
    logic [31:0] r_cfg_kd, n_cfg_kd;
    logic [31:0] r_cfg_tol, n_cfg_tol;
    logic [31:0] r_cfg_step, n_cfg_step;

    // controller and tuner state
    t_terms      r_terms, n_terms;
    t_gains      r_active, n_active;
    t_gains      r_trial, n_trial;
    logic [31:0] r_step [NUM_GAINS];
    logic [31:0] n_step [NUM_GAINS];
    t_gains      r_best, n_best;
    logic [31:0] r_best_err, n_best_err;
    logic        r_desc, n_desc;
    logic        r_started, n_started;
    logic [1:0]  r_gain_idx, n_gain_idx;
    logic [15:0] r_step_cnt, n_step_cnt;

    logic               out_adv;
    logic               fire;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    t_terms             drv_terms;
    logic signed [31:0] drv_val;
    logic signed [31:0] n_drive;
    logic               n_done;
    logic [1:0]         gi;
    logic [1:0]         gi_nx;
    logic [31:0]        step_cur;
    logic [31:0]        step_nx;
    logic               below;
    logic               improve;
    logic               advance;
    logic               load;
    logic [63:0]        recip_prod;
    logic [31:0]        q10;
    logic [31:0]        r10;
    logic [32:0]        up_sum;
    logic [31:0]        step_up;
    logic [31:0]        step_down;

    function automatic t_gain sat_add(input t_gain g, input logic signed [34:0] d);
        logic signed [34:0] s;
        s = 35'(g) + d;
        if (s > 35'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -35'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // handshake: result register parts the two sides
    assign out_adv     = !r_out_vld || o_res.ready;
    assign fire        = r_in_vld && out_adv;
    assign i_smp.ready = !r_in_vld || out_adv;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_idx     = paddr[4:2];

    // pid datapath
    pidt_drive u_drive (
        .i_err   (r_in_err),
        .i_terms (r_terms),
        .i_gains (r_active),
        .o_terms (drv_terms),
        .o_drive (drv_val)
    );

    // coordinate selection and tolerance check
    assign gi       = (r_gain_idx > G_KD) ? G_KP : r_gain_idx;
    assign gi_nx    = (gi == G_KD) ? G_KP : gi + 2'd1;
    assign step_cur = r_step[gi];
    assign step_nx  = r_step[gi_nx];
    assign below    = (34'(r_step[0]) + 34'(r_step[1]) + 34'(r_step[2])) < 34'(r_cfg_tol);
    assign improve  = r_in_sse < r_best_err;

    // step scaling by 1.1 and 0.9 through one divide-by-ten
    assign recip_prod = 64'(step_cur) * 64'(RECIP_10);
    assign q10        = 32'(recip_prod >> RECIP_SHIFT);
    assign r10        = step_cur - ((q10 << 3) + (q10 << 1));
    assign up_sum     = 33'(step_cur) + 33'(q10);
    assign step_up    = up_sum[32] ? 32'hFFFF_FFFF : up_sum[31:0];
    assign step_down  = step_cur - q10 - 32'(r10 != 32'd0);

    // next state
    always_comb begin
        n_cfg_kp   = r_cfg_kp;
        n_cfg_ki   = r_cfg_ki;
        n_cfg_kd   = r_cfg_kd;
        n_cfg_tol  = r_cfg_tol;
        n_cfg_step = r_cfg_step;
        n_terms    = r_terms;
        n_active   = r_active;
        n_trial    = r_trial;
        n_step     = r_step;
        n_best     = r_best;
        n_best_err = r_best_err;
        n_desc     = r_desc;
        n_started  = r_started;
        n_gain_idx = r_gain_idx;
        n_step_cnt = r_step_cnt;
        n_drive    = '0;
        n_done     = 1'b0;
        advance    = 1'b0;
        load       = 1'b0;

        if (fire) begin
            if (r_in_op == OP_SAMPLE) begin
                n_terms = drv_terms;
                n_drive = drv_val;
                n_done  = r_started && below;
            end else begin
                if (!r_started) begin
                    n_best_err  = r_in_sse;
                    n_best      = r_trial;
                    n_trial[gi] = sat_add(r_trial[gi], 35'(step_cur));
                    n_desc      = 1'b0;
                    n_started   = 1'b1;
                    load        = 1'b1;
                end else if (below) begin
                    n_done = 1'b1;
                end else if (!r_desc) begin
                    if (improve) begin
                        n_best_err = r_in_sse;
                        n_best     = r_trial;
                        n_step[gi] = step_up;
                        advance    = 1'b1;
                    end else begin
                        n_trial[gi] = sat_add(r_trial[gi], -(35'(step_cur) <<< 1));
                        n_desc      = 1'b1;
                    end
                    load = 1'b1;
                end else begin
                    if (improve) begin
                        n_best_err = r_in_sse;
                        n_best     = r_trial;
                        n_step[gi] = step_up;
                    end else begin
                        n_trial[gi] = sat_add(r_trial[gi], 35'(step_cur));
                        n_step[gi]  = step_down;
                    end
                    advance = 1'b1;
                    load    = 1'b1;
                end

                // move on to the next gain
                if (advance) begin
                    n_gain_idx     = gi_nx;
                    n_trial[gi_nx] = sat_add(r_trial[gi_nx], 35'(step_nx));
                    n_desc         = 1'b0;
                    if (r_step_cnt != 16'hFFFF) begin
                        n_step_cnt = r_step_cnt + 16'd1;
                    end
                end

                // new episode: clear terms, run on the trial gains
                if (load) begin
                    n_terms  = '0;
                    n_active = n_trial;
                end
            end
        end

        // register writes are for the user to make only while idle; the block does not enforce it
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KP_START: begin
                    n_cfg_kp = pwdata;
                    if (!r_started) n_active[G_KP] = pwdata;
                end
                REG_KI_START: begin
                    n_cfg_ki = pwdata;
                    if (!r_started) n_active[G_KI] = pwdata;
                end
                REG_KD_START: begin
                    n_cfg_kd = pwdata;
                    if (!r_started) n_active[G_KD] = pwdata;
                end
                REG_TOLERANCE: begin
                    n_cfg_tol = pwdata;
                end
                REG_START_STEP: begin
                    n_cfg_step = pwdata;
                    if (!r_started) begin
                        for (int k = 0; k < NUM_GAINS; k++) n_step[k] = pwdata;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (cfg_idx)
            REG_KP_START:   prdata = r_cfg_kp;
            REG_KI_START:   prdata = r_cfg_ki;
            REG_KD_START:   prdata = r_cfg_kd;
            REG_TOLERANCE:  prdata = r_cfg_tol;
            REG_START_STEP: prdata = r_cfg_step;
            default:        prdata = '0;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_kp   <= '0;
            r_cfg_ki   <= '0;
            r_cfg_kd   <= '0;
            r_cfg_tol  <= TOL_RESET;
            r_cfg_step <= STEP_RESET;
            r_terms    <= '0;
            r_best_err <= 32'hFFFF_FFFF;
            r_desc     <= 1'b0;
            r_started  <= 1'b0;
            r_gain_idx <= G_KP;
            r_step_cnt <= '0;
            for (int k = 0; k < NUM_GAINS; k++) begin
                r_active[k] <= '0;
                r_trial[k]  <= '0;
                r_step[k]   <= STEP_RESET;
                r_best[k]   <= '0;
            end
        end else begin
            r_cfg_kp   <= n_cfg_kp;
            r_cfg_ki   <= n_cfg_ki;
            r_cfg_kd   <= n_cfg_kd;
            r_cfg_tol  <= n_cfg_tol;
            r_cfg_step <= n_cfg_step;
            r_terms    <= n_terms;
            r_active   <= n_active;
            r_trial    <= n_trial;
            r_step     <= n_step;
            r_best     <= n_best;
            r_best_err <= n_best_err;
            r_desc     <= n_desc;
            r_started  <= n_started;
            r_gain_idx <= n_gain_idx;
            r_step_cnt <= n_step_cnt;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_vld <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_in_op  <= i_smp.opcode;
            r_in_err <= i_smp.error_sample;
            r_in_sse <= i_smp.episode_sse;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_drive <= n_drive;
            r_out_done  <= n_done;
            r_out_best  <= n_best;
            r_out_steps <= n_step_cnt;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.drive       = r_out_drive;
    assign o_res.tuning_done = r_out_done;
    assign o_res.best_kp     = r_out_best[G_KP];
    assign o_res.best_ki     = r_out_best[G_KI];
    assign o_res.best_kd     = r_out_best[G_KD];
    assign o_res.tune_steps  = r_out_steps;

    // checks
    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_step_cnt >= $past(r_step_cnt))
        else $error("tuning step count went backwards");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_step_cnt == 16'd0 && !r_desc))
        else $error("tuner state moved before tuning started");

    a_desc_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_op == OP_TUNE && r_started && r_desc && !below) |=> !r_desc)
        else $error("descent step did not return to ascent");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_adv) |=> (r_in_vld && $stable(r_in_err) && $stable(r_in_op)))
        else $error("stalled input register lost its transaction");

endmodule
